// ----- hw/rtl/mbpf_pkg.sv -----
// ----------------------------------------------------------------------------
// mbpf_pkg
// Shared sizes, types and helpers of the mask boundary point finder.
// ----------------------------------------------------------------------------
package mbpf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_SIZE   = 3;
  localparam int MIN_NBRS   = 3;
  localparam int ALL_NBRS   = 8;

  localparam int SIZE_W = 11;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int IDX_W  = 20;
  localparam int CNT_W  = 4;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic             int_hit;
    logic [IDX_W-1:0] int_idx;
    logic             bor_hit;
    logic [IDX_W-1:0] bor_idx;
  } qent_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] res;
    res = v;
    if (v < SIZE_W'(MIN_SIZE)) res = SIZE_W'(MIN_SIZE);
    else if (v > maxv) res = maxv;
    return res;
  endfunction

endpackage

// ----- hw/rtl/mbpf_if.sv -----
// ----------------------------------------------------------------------------
// mbpf_if
// Valid/ready channels of the mask boundary point finder.
// ----------------------------------------------------------------------------
interface mbpf_in_if;
  logic valid;
  logic ready;
  logic point_unblanked;

  modport source (output valid, output point_unblanked, input ready);
  modport sink   (input valid, input point_unblanked, output ready);
endinterface

interface mbpf_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] point_index;
  logic        point_on_border;
  logic        last_in_run;

  modport source (output valid, output point_index, output point_on_border,
                  output last_in_run, input ready);
  modport sink   (input valid, input point_index, input point_on_border,
                  input last_in_run, output ready);
endinterface

// ----- hw/rtl/mbpf_front.sv -----
// ----------------------------------------------------------------------------
// mbpf_front
// Raster tracking, line buffers and 3x3 window; classifies each point.
// ----------------------------------------------------------------------------
module mbpf_front
  import mbpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic [SIZE_W-1:0] w_eff,
  input  logic [SIZE_W-1:0] h_eff,
  mbpf_in_if.sink           mask,
  output logic              push,
  output qent_t             push_data,
  input  logic              full
);

  logic [1:0]       line_mem [MAX_WIDTH];
  logic [1:0]       rd;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [IDX_W-1:0] base;

  logic             a_v;
  logic             a_b;
  logic [COL_W-1:0] a_col;
  logic             a_border;
  logic             a_inner;
  logic [IDX_W-1:0] a_base;

  logic [2:0]       win1;
  logic [2:0]       win2;
  logic [2:0]       col_new;
  logic [CNT_W-1:0] cnt;

  logic             acc;
  logic             adv;
  logic             any_hit;
  logic             row_end;
  logic             grid_end;
  logic             on_edge;

  assign acc = mask.valid && mask.ready;
  assign mask.ready = !a_v || adv;

  assign row_end  = (SIZE_W'(col) + SIZE_W'(1)) == w_eff;
  assign grid_end = (SIZE_W'(row) + SIZE_W'(1)) == h_eff;
  assign on_edge  = (col == '0) || (SIZE_W'(col) == w_eff - SIZE_W'(1)) ||
                    (row == '0) || (SIZE_W'(row) == h_eff - SIZE_W'(1));

  // new column: bit0 two rows up, bit1 row above, bit2 this row
  assign col_new = {a_b, rd[1], rd[0]};

  assign cnt = CNT_W'(win2[0]) + CNT_W'(win2[1]) + CNT_W'(win2[2]) +
               CNT_W'(win1[0]) + CNT_W'(win1[2]) +
               CNT_W'(col_new[0]) + CNT_W'(col_new[1]) + CNT_W'(col_new[2]);

  always_comb begin
    push_data.int_hit = a_inner && win1[1] && (cnt >= CNT_W'(MIN_NBRS)) &&
                        (cnt < CNT_W'(ALL_NBRS));
    push_data.int_idx = IDX_W'(a_col) - IDX_W'(1) + a_base - IDX_W'(w_eff);
    push_data.bor_hit = a_border;
    push_data.bor_idx = IDX_W'(a_col) + a_base;
  end

  assign any_hit = push_data.int_hit || push_data.bor_hit;
  assign adv     = a_v && (!any_hit || !full);
  assign push    = a_v && any_hit && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      base <= '0;
      a_v  <= 1'b0;
      win1 <= '0;
      win2 <= '0;
    end else if (restart) begin
      col  <= '0;
      row  <= '0;
      base <= '0;
      win1 <= '0;
      win2 <= '0;
    end else begin
      if (acc) begin
        if (row_end) begin
          col <= '0;
          if (grid_end) begin
            row  <= '0;
            base <= '0;
          end else begin
            row  <= row + ROW_W'(1);
            base <= base + IDX_W'(w_eff);
          end
        end else begin
          col <= col + COL_W'(1);
        end
      end
      if (acc) begin
        a_v <= 1'b1;
      end else if (adv) begin
        a_v <= 1'b0;
      end
      if (adv) begin
        win2 <= win1;
        win1 <= col_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_b      <= mask.point_unblanked;
      a_col    <= col;
      a_border <= mask.point_unblanked && on_edge;
      a_inner  <= (row >= ROW_W'(2)) && (col >= COL_W'(2));
      a_base   <= base;
    end
  end

  // line buffers: read at acceptance, updated as the point leaves
  always_ff @(posedge clk) begin
    if (acc) begin
      rd <= line_mem[col];
    end
    if (adv) begin
      line_mem[a_col] <= {a_b, rd[1]};
    end
  end

endmodule

// ----- hw/rtl/mbpf_queue.sv -----
// ----------------------------------------------------------------------------
// mbpf_queue
// Short queue of classified points between front and back.
// ----------------------------------------------------------------------------
module mbpf_queue
  import mbpf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output qent_t head,
  output logic  empty
);

  qent_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W+1)'(QDEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/mbpf_back.sv -----
// ----------------------------------------------------------------------------
// mbpf_back
// Expands each queued point into its results; one beat per cycle while ready.
// ----------------------------------------------------------------------------
module mbpf_back
  import mbpf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  qent_t   head,
  input  logic    empty,
  output logic    pop,
  mbpf_out_if.source result
);

  logic phase;
  logic load;
  logic emit_int;

  assign load     = !empty && (!result.valid || result.ready);
  assign emit_int = head.int_hit && !phase;
  assign pop      = load && !(emit_int && head.bor_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      phase        <= 1'b0;
    end else begin
      if (load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (load) begin
        phase <= emit_int && head.bor_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_int) begin
        result.point_index     <= head.int_idx;
        result.point_on_border <= 1'b0;
        result.last_in_run     <= !head.bor_hit;
      end else begin
        result.point_index     <= head.bor_idx;
        result.point_on_border <= 1'b1;
        result.last_in_run     <= 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/mask_boundary_point_finder.sv -----
// ----------------------------------------------------------------------------
// mask_boundary_point_finder
// Finds boundary points of a blanking mask streamed in raster order.
// ----------------------------------------------------------------------------
// usage:
// mask carries one mask bit per beat, row by row; result carries the linear
// index of each boundary point, a border flag and a last-in-run mark.
// an interior point is reported when the point below-right of it arrives,
// first the interior result, then the border result of the arriving point.
// throughput: one mask point per cycle; results leave at one per cycle while
// result is ready, so a point with two results holds the back end for both. a
// result passes the front stage, a queue slot and the result register. a
// four-entry queue sits between front and back; when result stalls the queue
// fills and mask ready drops only once it is full. grid_width (address 0) and
// grid_height (address 4) are written over apb while idle, which the user must
// ensure as the block does not enforce it. a write restarts the grid at row 0,
// column 0. reset clears the raster position, window and queue; sizes return
// to 1024. line buffer contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module mask_boundary_point_finder
  import mbpf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  mbpf_in_if.sink           mask,
  mbpf_out_if.source        result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [SIZE_W-1:0] grid_width;
  logic [SIZE_W-1:0] grid_height;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;
  logic              cfg_wr;

  logic  q_push;
  qent_t q_in;
  logic  q_full;
  logic  q_pop;
  qent_t q_head;
  logic  q_empty;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_HEIGHT) ? DATA_W'(grid_height) : DATA_W'(grid_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= SIZE_W'(MAX_WIDTH);
      grid_height <= SIZE_W'(MAX_HEIGHT);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        grid_width <= pwdata[SIZE_W-1:0];
      end else begin
        grid_height <= pwdata[SIZE_W-1:0];
      end
    end
  end

  assign w_eff = clamp_size(grid_width, SIZE_W'(MAX_WIDTH));
  assign h_eff = clamp_size(grid_height, SIZE_W'(MAX_HEIGHT));

  mbpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (cfg_wr),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .mask      (mask),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full)
  );

  mbpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  mbpf_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .empty  (q_empty),
    .pop    (q_pop),
    .result (result)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full))
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("queue read while empty");

  a_first_is_interior: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.last_in_run) |-> !result.point_on_border)
    else $error("non-final result is not an interior point");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");
`endif

endmodule
